// ===== hdl/latency_histogram_percentile_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_DEFINES_SVH

// Check cons in the same cycle as ante; skip while reset is asserted.
`define LHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante; skip while reset is asserted.
`define LHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lhp_pkg.sv =====
package lhp_pkg;

  localparam int NUM_BUCKETS_DEF   = 20;
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int LATENCY_WIDTH_DEF = 40;

  localparam int KIND_W = 2;
  localparam int PCT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_NOTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Lowest bucket bound; the others follow by x2.5, x2, x2.
  localparam int BOUND_FIRST = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NRD,
    ST_NWR,
    ST_QMUL,
    ST_QWALK,
    ST_FIN
  } lhp_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

  typedef struct packed {
    logic restart;
    logic advance;
  } bound_ctl_t;

endpackage

// ===== hdl/lhp_if.sv =====
interface lhp_in_if #(
  parameter int LATENCY_WIDTH = lhp_pkg::LATENCY_WIDTH_DEF
);
  import lhp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [LATENCY_WIDTH-1:0] latency_us;
  logic                     succeeded;
  logic [PCT_W-1:0]         percent_rank;

  modport source (output valid, kind, latency_us, succeeded, percent_rank, input ready);
  modport sink   (input valid, kind, latency_us, succeeded, percent_rank, output ready);
endinterface

interface lhp_out_if #(
  parameter int COUNT_WIDTH   = lhp_pkg::COUNT_WIDTH_DEF,
  parameter int LATENCY_WIDTH = lhp_pkg::LATENCY_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [LATENCY_WIDTH-1:0] percentile_us;
  logic [COUNT_WIDTH-1:0]   success_total;
  logic [COUNT_WIDTH-1:0]   failure_total;
  logic [LATENCY_WIDTH-1:0] max_us;
  logic [LATENCY_WIDTH-1:0] last_us;

  modport source (output valid, percentile_us, success_total, failure_total, max_us,
                  last_us, input ready);
  modport sink   (input valid, percentile_us, success_total, failure_total, max_us,
                  last_us, output ready);
endinterface

// ===== hdl/lhp_bucket_mem.sv =====
module lhp_bucket_mem #(
  parameter int DEPTH = lhp_pkg::NUM_BUCKETS_DEF,
  parameter int WIDTH = lhp_pkg::COUNT_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lhp_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);
  import lhp_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // An entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== hdl/lhp_bound_step.sv =====
module lhp_bound_step #(
  parameter int LATENCY_WIDTH = lhp_pkg::LATENCY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lhp_pkg::bound_ctl_t      ctl,
  output logic [LATENCY_WIDTH-1:0] bound
);
  import lhp_pkg::*;

  localparam int WW = LATENCY_WIDTH + 2;
  localparam logic [LATENCY_WIDTH-1:0] MASK = {LATENCY_WIDTH{1'b1}};

  // Position of the bound within its decade: 10, 25 or 50 times a power of ten.
  localparam logic [1:0] PH_TEN        = 2'd0;
  localparam logic [1:0] PH_TWENTYFIVE = 2'd1;
  localparam logic [1:0] PH_FIFTY      = 2'd2;

  logic [LATENCY_WIDTH-1:0] bound_r, bound_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic [WW-1:0]            grown;

  always_comb begin
    grown     = {1'b0, bound_r, 1'b0};
    if (phase_r == PH_TEN) begin
      grown = grown + WW'(bound_r >> 1);
    end
    bound_nxt = bound_r;
    phase_nxt = phase_r;
    if (ctl.restart) begin
      bound_nxt = LATENCY_WIDTH'(BOUND_FIRST);
      phase_nxt = PH_TEN;
    end else if (ctl.advance) begin
      // Hold at all ones once the sequence runs past the latency width.
      bound_nxt = (grown > WW'(MASK)) ? MASK : grown[LATENCY_WIDTH-1:0];
      unique case (phase_r)
        PH_TEN:        phase_nxt = PH_TWENTYFIVE;
        PH_TWENTYFIVE: phase_nxt = PH_FIFTY;
        default:       phase_nxt = PH_TEN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEN;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bound_r <= bound_nxt;
  end

  assign bound = bound_r;
endmodule

// ===== hdl/latency_histogram_percentile.sv =====
// Channel  | Role   | Word
// ---------+--------+-----------------------------------------------------------
// in_chan  | sink   | kind, latency_us, succeeded, percent_rank
// out_chan | source | percentile_us, success_total, failure_total, max_us, last_us
//
// One word at a time. A failed note, a clear, an unused kind or a query with no
// successes goes straight to the finish state and loads its result into the
// output register; a successful note landing in bucket k first scans the bounds
// (one bucket a cycle), then reads and writes that bucket's count; a query first
// forms its target, then walks the buckets (one bucket memory read a cycle, then
// multiply-by-100 and accumulate stages). Reset clears everything at once through
// per-bucket valid bits; there is no clearing pass. A new word is taken while the
// last result still waits in the output register; a finished item holds until
// that register frees.
module latency_histogram_percentile #(
  parameter int NUM_BUCKETS   = lhp_pkg::NUM_BUCKETS_DEF,
  parameter int COUNT_WIDTH   = lhp_pkg::COUNT_WIDTH_DEF,
  parameter int LATENCY_WIDTH = lhp_pkg::LATENCY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lhp_in_if.sink     in_chan,
  lhp_out_if.source  out_chan
);
  import lhp_pkg::*;

  localparam int CW     = COUNT_WIDTH;
  localparam int LW     = LATENCY_WIDTH;
  localparam int IDX_W  = $clog2(NUM_BUCKETS);
  localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
  localparam int TGT_W  = CW + PCT_W;
  localparam int ACC_W  = CW + IDX_W + PCT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);
  localparam logic [LW-1:0]    LAT_MAX  = {LW{1'b1}};

  lhp_state_t st_r, st_nxt;

  logic [LW-1:0]    lat_r, lat_nxt;
  logic [PCT_W-1:0] pct_r, pct_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic             s2_v_r, s2_v_nxt;
  logic [TGT_W-1:0] b100_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [TGT_W-1:0] target_r, target_nxt;
  logic [LW-1:0]    pval_r, pval_nxt;
  logic [CW-1:0]    succ_r, succ_nxt;
  logic [CW-1:0]    fail_r, fail_nxt;
  logic [LW-1:0]    max_r, max_nxt;
  logic [LW-1:0]    last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LW-1:0]    out_pct_r, out_pct_nxt;
  logic [CW-1:0]    out_succ_r, out_succ_nxt;
  logic [CW-1:0]    out_fail_r, out_fail_nxt;
  logic [LW-1:0]    out_max_r, out_max_nxt;
  logic [LW-1:0]    out_last_r, out_last_nxt;

  mem_ctl_t         mctl;
  bound_ctl_t       bctl;
  logic [IDX_W-1:0] rd_addr;
  logic [CW-1:0]    wr_data;
  logic [CW-1:0]    rd_data;
  logic [LW-1:0]    bound;
  logic [LW-1:0]    cur_bound;
  logic [ACC_W-1:0] acc_sum;
  logic             issue;
  logic             reached;

  lhp_bucket_mem #(
    .DEPTH (NUM_BUCKETS),
    .WIDTH (CW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .rd_addr (rd_addr),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  lhp_bound_step #(
    .LATENCY_WIDTH (LW)
  ) u_bound (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bctl),
    .bound (bound)
  );

  // Query walk: one address a cycle; the read and x100 product are registered.
  assign issue     = (st_r == ST_QWALK) && (rd_cnt_r < CNT_W'(NUM_BUCKETS));
  assign rd_addr   = (st_r == ST_NRD) ? idx_r : rd_cnt_r[IDX_W-1:0];
  assign wr_data   = (&rd_data) ? rd_data : rd_data + 1'b1;
  assign cur_bound = (idx_r == LAST_IDX) ? LAT_MAX : bound;
  // sum >= ceil(count * pct / 100) exactly when 100 * sum >= count * pct.
  assign acc_sum   = acc_r + ACC_W'(b100_r);
  assign reached   = (acc_sum >= ACC_W'(target_r)) || (idx_r == LAST_IDX);

  always_comb begin
    st_nxt        = st_r;
    lat_nxt       = lat_r;
    pct_nxt       = pct_r;
    idx_nxt       = idx_r;
    rd_cnt_nxt    = rd_cnt_r;
    s1_v_nxt      = issue;
    s2_v_nxt      = 1'b0;
    acc_nxt       = acc_r;
    target_nxt    = target_r;
    pval_nxt      = pval_r;
    succ_nxt      = succ_r;
    fail_nxt      = fail_r;
    max_nxt       = max_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_pct_nxt   = out_pct_r;
    out_succ_nxt  = out_succ_r;
    out_fail_nxt  = out_fail_r;
    out_max_nxt   = out_max_r;
    out_last_nxt  = out_last_r;
    mctl          = '0;
    bctl          = '0;
    in_chan.ready = (st_r == ST_IDLE);

    unique case (st_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          lat_nxt      = in_chan.latency_us;
          pct_nxt      = (in_chan.percent_rank > PCT_MAX) ? PCT_MAX : in_chan.percent_rank;
          pval_nxt     = '0;
          idx_nxt      = '0;
          bctl.restart = 1'b1;
          unique case (in_chan.kind)
            KIND_NOTE: begin
              last_nxt = in_chan.latency_us;
              if (in_chan.succeeded) begin
                succ_nxt = (&succ_r) ? succ_r : succ_r + 1'b1;
                if (in_chan.latency_us > max_r) begin
                  max_nxt = in_chan.latency_us;
                end
                st_nxt = ST_SCAN;
              end else begin
                fail_nxt = (&fail_r) ? fail_r : fail_r + 1'b1;
                st_nxt   = ST_FIN;
              end
            end
            KIND_QUERY: begin
              // No successes: answer zero without walking.
              st_nxt = (succ_r == '0) ? ST_FIN : ST_QMUL;
            end
            KIND_CLEAR: begin
              succ_nxt = '0;
              fail_nxt = '0;
              max_nxt  = '0;
              last_nxt = '0;
              mctl.clr = 1'b1;
              st_nxt   = ST_FIN;
            end
            default: begin
              // Unused kind: report state unchanged.
              st_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Advance to the first bucket whose bound covers the latency.
        if ((idx_r == LAST_IDX) || (bound >= lat_r)) begin
          st_nxt = ST_NRD;
        end else begin
          idx_nxt      = idx_r + 1'b1;
          bctl.advance = 1'b1;
        end
      end
      ST_NRD: begin
        mctl.rd_en = 1'b1;
        st_nxt     = ST_NWR;
      end
      ST_NWR: begin
        mctl.wr_en = 1'b1;
        st_nxt     = ST_FIN;
      end
      ST_QMUL: begin
        target_nxt = TGT_W'(succ_r) * TGT_W'(pct_r);
        acc_nxt    = '0;
        rd_cnt_nxt = '0;
        st_nxt     = ST_QWALK;
      end
      ST_QWALK: begin
        mctl.rd_en = issue;
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        s2_v_nxt = s1_v_r;
        if (s2_v_r) begin
          if (reached) begin
            pval_nxt = cur_bound;
            s1_v_nxt = 1'b0;
            s2_v_nxt = 1'b0;
            st_nxt   = ST_FIN;
          end else begin
            acc_nxt      = acc_sum;
            idx_nxt      = idx_r + 1'b1;
            bctl.advance = 1'b1;
          end
        end
      end
      ST_FIN: begin
        // Load the result only once the output register is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = pval_r;
          out_succ_nxt  = succ_r;
          out_fail_nxt  = fail_r;
          out_max_nxt   = max_r;
          out_last_nxt  = last_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      succ_r      <= '0;
      fail_r      <= '0;
      max_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      succ_r      <= succ_nxt;
      fail_r      <= fail_nxt;
      max_r       <= max_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_r      <= lat_nxt;
    pct_r      <= pct_nxt;
    idx_r      <= idx_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    b100_r     <= TGT_W'(rd_data) * TGT_W'(PCT_MAX);
    acc_r      <= acc_nxt;
    target_r   <= target_nxt;
    pval_r     <= pval_nxt;
    out_pct_r  <= out_pct_nxt;
    out_succ_r <= out_succ_nxt;
    out_fail_r <= out_fail_nxt;
    out_max_r  <= out_max_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.percentile_us = out_pct_r;
  assign out_chan.success_total = out_succ_r;
  assign out_chan.failure_total = out_fail_r;
  assign out_chan.max_us        = out_max_r;
  assign out_chan.last_us       = out_last_r;
endmodule

// ===== hdl/lhp_checker.sv =====
`include "latency_histogram_percentile_defines.svh"

module lhp_checker #(
  parameter int COUNT_WIDTH   = lhp_pkg::COUNT_WIDTH_DEF,
  parameter int LATENCY_WIDTH = lhp_pkg::LATENCY_WIDTH_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [LATENCY_WIDTH-1:0] out_percentile_us,
  input logic [COUNT_WIDTH-1:0]   out_success_total,
  input logic [COUNT_WIDTH-1:0]   out_failure_total,
  input logic [LATENCY_WIDTH-1:0] out_max_us,
  input logic [LATENCY_WIDTH-1:0] out_last_us
);
  import lhp_pkg::*;

  // A stalled result word holds.
  `LHP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_percentile_us) && $stable(out_success_total) &&
    $stable(out_failure_total) && $stable(out_max_us) && $stable(out_last_us),
    "stalled result word changed")

  // One word at a time: drop ready right after an accepted word.
  `LHP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready,
    "input accepted on consecutive cycles")

  `LHP_ASSERT_NOW(a_empty_query, clk, rst_n, out_valid && (out_success_total == '0),
    out_percentile_us == '0, "nonzero percentile with no successes")

  `LHP_ASSERT_NOW(a_max_needs_success, clk, rst_n, out_valid && (out_max_us != '0),
    out_success_total != '0, "maximum recorded without any success")
endmodule

bind latency_histogram_percentile lhp_checker #(
  .COUNT_WIDTH   (COUNT_WIDTH),
  .LATENCY_WIDTH (LATENCY_WIDTH)
) u_lhp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_percentile_us (out_chan.percentile_us),
  .out_success_total (out_chan.success_total),
  .out_failure_total (out_chan.failure_total),
  .out_max_us        (out_chan.max_us),
  .out_last_us       (out_chan.last_us)
);

// ===== tb/sv/tb_latency_histogram_percentile.sv =====
`timescale 1ns / 1ps

module tb_latency_histogram_percentile;
  import lhp_pkg::*;

  localparam int NB = NUM_BUCKETS_DEF;
  localparam int CW = COUNT_WIDTH_DEF;
  localparam int LW = LATENCY_WIDTH_DEF;

  // Kind code the block leaves unused; it must report the state unchanged.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [63:0] LAT_ALL = (64'd1 << LW) - 64'd1;

  // Cycles to wait after the drain, to catch any stray reply word.
  localparam int DRAIN_CYCLES   = 40;
  // Cycles without any accepted word before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS   = 1000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LW-1:0]     latency_us;
    logic              succeeded;
    logic [PCT_W-1:0]  percent_rank;
  } stat_cmd_t;

  typedef struct packed {
    logic [LW-1:0] percentile_us;
    logic [CW-1:0] success_total;
    logic [CW-1:0] failure_total;
    logic [LW-1:0] max_us;
    logic [LW-1:0] last_us;
  } stat_reply_t;

  // Histogram mirror: tracks the statistics store and queues the reply each
  // accepted command word should produce.
  class histogram_scoreboard;
    logic [CW-1:0] bucket_hits [NB];
    logic [CW-1:0] ok_count;
    logic [CW-1:0] fail_count;
    logic [LW-1:0] peak_lat;
    logic [LW-1:0] recent_lat;
    stat_reply_t   replies_due[$];
    int            errors;

    function new();
      wipe_stats();
      errors = 0;
    endfunction

    // Upper bound of bucket idx: 10, 25, 50 times powers of ten, capped.
    static function logic [63:0] bucket_limit(int idx);
      logic [63:0] v;
      if (idx >= NB - 1) return LAT_ALL;
      case (idx % 3)
        0: v = 64'd10;
        1: v = 64'd25;
        default: v = 64'd50;
      endcase
      for (int k = 0; k < idx / 3; k++) begin
        if (v > LAT_ALL / 10) return LAT_ALL;
        v = v * 10;
      end
      return (v > LAT_ALL) ? LAT_ALL : v;
    endfunction

    function void wipe_stats();
      foreach (bucket_hits[i]) bucket_hits[i] = '0;
      ok_count   = '0;
      fail_count = '0;
      peak_lat   = '0;
      recent_lat = '0;
    endfunction

    function logic [CW-1:0] bump(logic [CW-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function logic [LW-1:0] rank_bound(logic [PCT_W-1:0] pct);
      logic [63:0] p;
      logic [63:0] rank;
      logic [63:0] running;
      if (ok_count == '0) return '0;
      p = (pct > PCT_MAX) ? 64'(PCT_MAX) : 64'(pct);
      // rank = ceil(count * p / 100) without overflow
      rank = (64'(ok_count) / 100) * p + ((64'(ok_count) % 100) * p + 99) / 100;
      running = '0;
      for (int i = 0; i < NB; i++) begin
        running = running + 64'(bucket_hits[i]);
        if (running >= rank) return LW'(bucket_limit(i));
      end
      return LW'(bucket_limit(NB - 1));
    endfunction

    // Advance the mirror by one accepted command and queue its reply.
    function void note_word(stat_cmd_t w);
      stat_reply_t r;
      int b;
      r.percentile_us = '0;
      case (w.kind)
        KIND_NOTE: begin
          recent_lat = w.latency_us;
          if (!w.succeeded) begin
            fail_count = bump(fail_count);
          end else begin
            ok_count = bump(ok_count);
            if (w.latency_us > peak_lat) peak_lat = w.latency_us;
            b = 0;
            while (b < NB - 1 && bucket_limit(b) < 64'(w.latency_us)) b++;
            bucket_hits[b] = bump(bucket_hits[b]);
          end
        end
        KIND_QUERY: r.percentile_us = rank_bound(w.percent_rank);
        KIND_CLEAR: wipe_stats();
        default: ;
      endcase
      r.success_total = ok_count;
      r.failure_total = fail_count;
      r.max_us        = peak_lat;
      r.last_us       = recent_lat;
      replies_due.push_back(r);
    endfunction

    task report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
      errors++;
    endtask

    // Compare one accepted reply against the oldest queued one.
    task check_reply(stat_reply_t got);
      stat_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t reply word with nothing outstanding", $time);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.percentile_us !== want.percentile_us)
        report("percentile_us", 64'(want.percentile_us), 64'(got.percentile_us));
      if (got.success_total !== want.success_total)
        report("success_total", 64'(want.success_total), 64'(got.success_total));
      if (got.failure_total !== want.failure_total)
        report("failure_total", 64'(want.failure_total), 64'(got.failure_total));
      if (got.max_us !== want.max_us)
        report("max_us", 64'(want.max_us), 64'(got.max_us));
      if (got.last_us !== want.last_us)
        report("last_us", 64'(want.last_us), 64'(got.last_us));
    endtask

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lhp_in_if  in_chan ();
  lhp_out_if out_chan ();

  latency_histogram_percentile dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  histogram_scoreboard hist_sb;

  // Idle chances in percent for the command sender and the reply receiver.
  int send_idle;
  int recv_idle;
  int stall_cycles;

  always #5 clk = ~clk;

  // Drop ready on the reply side at random, per the current phase.
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Sample both handshakes at the edge; feed the mirror and the checker.
  always @(posedge clk) begin
    stat_cmd_t   cmd;
    stat_reply_t rep;
    logic        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_chan.valid && in_chan.ready) begin
        cmd.kind         = in_chan.kind;
        cmd.latency_us   = in_chan.latency_us;
        cmd.succeeded    = in_chan.succeeded;
        cmd.percent_rank = in_chan.percent_rank;
        hist_sb.note_word(cmd);
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        rep.percentile_us = out_chan.percentile_us;
        rep.success_total = out_chan.success_total;
        rep.failure_total = out_chan.failure_total;
        rep.max_us        = out_chan.max_us;
        rep.last_us       = out_chan.last_us;
        hist_sb.check_reply(rep);
        moved = 1'b1;
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[latency_histogram_percentile] ERROR");
        $finish;
      end
    end
  end

  // Present one command word and hold it until the block takes it. Valid is
  // left high on return so back-to-back words need no second assignment.
  task automatic send_word(stat_cmd_t w);
    while ($urandom_range(99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.kind         <= w.kind;
    in_chan.latency_us   <= w.latency_us;
    in_chan.succeeded    <= w.succeeded;
    in_chan.percent_rank <= w.percent_rank;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_cmd(logic [KIND_W-1:0] kind, logic [LW-1:0] lat, logic ok,
                          logic [PCT_W-1:0] pct);
    stat_cmd_t w;
    w.kind         = kind;
    w.latency_us   = lat;
    w.succeeded    = ok;
    w.percent_rank = pct;
    send_word(w);
  endtask

  // Pick a latency that mostly sits on or around a bucket edge, so every
  // bucket and both sides of each bound get hit.
  function automatic logic [LW-1:0] pick_latency();
    logic [63:0] raw;
    logic [63:0] hi;
    logic [63:0] lo;
    int b;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return raw[LW-1:0];
      1: return '0;
      default: begin
        b  = $urandom_range(NB - 1);
        hi = histogram_scoreboard::bucket_limit(b);
        lo = (b == 0) ? 64'd0 : histogram_scoreboard::bucket_limit(b - 1);
        case ($urandom_range(3))
          0: return hi[LW-1:0];
          1: return lo[LW-1:0] + 1'b1;
          2: return (b < NB - 1) ? hi[LW-1:0] + 1'b1 : hi[LW-1:0];
          default: return lo[LW-1:0] + 1'b1 + LW'(raw % (hi - lo));
        endcase
      end
    endcase
  endfunction

  function automatic logic [PCT_W-1:0] pick_percent();
    logic [PCT_W-1:0] usual [7] = '{7'd0, 7'd1, 7'd50, 7'd90, 7'd95, 7'd99, PCT_MAX};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return usual[$urandom_range(6)];
      5, 6, 7:       return PCT_W'($urandom_range(100));
      default:       return PCT_W'($urandom_range(127));
    endcase
  endfunction

  // Mostly notes and queries; clears are rare so the histogram fills up.
  function automatic stat_cmd_t pick_cmd();
    stat_cmd_t w;
    int roll;
    logic [63:0] raw;
    raw            = {$urandom, $urandom};
    roll           = $urandom_range(99);
    w.latency_us   = raw[LW-1:0];
    w.succeeded    = 1'($urandom_range(1));
    w.percent_rank = PCT_W'($urandom_range(127));
    if (roll < 68) begin
      w.kind       = KIND_NOTE;
      w.latency_us = pick_latency();
      w.succeeded  = ($urandom_range(99) < 85);
    end else if (roll < 94) begin
      w.kind         = KIND_QUERY;
      w.percent_rank = pick_percent();
    end else if (roll < 98) begin
      w.kind = KIND_SPARE;
    end else begin
      w.kind = KIND_CLEAR;
    end
    return w;
  endfunction

  initial begin
    hist_sb              = new();
    stall_cycles         = 0;
    send_idle            = 16;
    recv_idle            = 61;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.kind         = KIND_NOTE;
    in_chan.latency_us   = '0;
    in_chan.succeeded    = 1'b0;
    in_chan.percent_rank = '0;
    out_chan.ready       = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, bucket edges, percent extremes, spare kind, clear.
    send_cmd(KIND_QUERY, '0, 1'b1, 7'd50);
    send_cmd(KIND_NOTE, '0, 1'b0, 7'd0);
    send_cmd(KIND_NOTE, '0, 1'b1, 7'd0);
    send_cmd(KIND_NOTE, LW'(10), 1'b1, '1);
    send_cmd(KIND_NOTE, LW'(11), 1'b1, '1);
    send_cmd(KIND_NOTE, LW'(10000000), 1'b1, 7'd0);
    send_cmd(KIND_NOTE, LW'(10000001), 1'b1, 7'd0);
    send_cmd(KIND_NOTE, '1, 1'b1, 7'd0);
    send_cmd(KIND_NOTE, '1, 1'b0, '1);
    send_cmd(KIND_NOTE, LW'(5), 1'b0, 7'd0);
    send_cmd(KIND_QUERY, '1, 1'b0, 7'd0);
    send_cmd(KIND_QUERY, '0, 1'b1, 7'd1);
    send_cmd(KIND_QUERY, '0, 1'b0, 7'd50);
    send_cmd(KIND_QUERY, '0, 1'b1, 7'd99);
    send_cmd(KIND_QUERY, '0, 1'b1, PCT_MAX);
    send_cmd(KIND_QUERY, '1, 1'b1, 7'd101);
    send_cmd(KIND_QUERY, '0, 1'b1, '1);
    send_cmd(KIND_SPARE, '1, 1'b1, '1);
    send_cmd(KIND_SPARE, '0, 1'b0, 7'd0);
    send_cmd(KIND_CLEAR, '1, 1'b1, '1);
    send_cmd(KIND_QUERY, '0, 1'b1, PCT_MAX);
    send_cmd(KIND_NOTE, LW'(25), 1'b1, 7'd0);
    send_cmd(KIND_QUERY, '0, 1'b0, 7'd0);

    // Random: receiver mostly idle first, then sender mostly idle, then no gaps.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        send_idle = 61;
        recv_idle = 16;
      end else if (i == 2 * RANDOM_WORDS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send_word(pick_cmd());
    end
    in_chan.valid <= 1'b0;

    // Drain outstanding replies, then linger to catch any stray word.
    while (hist_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (hist_sb.errors == 0) begin
      $display("[latency_histogram_percentile] OK");
    end else begin
      $display("[latency_histogram_percentile] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/lhp_pkg.sv
hdl/lhp_if.sv
hdl/lhp_bucket_mem.sv
hdl/lhp_bound_step.sv
hdl/latency_histogram_percentile.sv
hdl/lhp_checker.sv
tb/sv/tb_latency_histogram_percentile.sv
